### design/zrld_pkg.sv
// Shared constants and control types for the zero-run-length decoder.
package zrld_pkg;

  localparam int BLOCK_LEN_DEF = 64;
  localparam int WORD_W        = 16;

  // Commands from the top level to the run counter, one cycle each.
  typedef struct packed {
    logic load_coeff;  // a coefficient transaction left: count it
    logic load_run;    // a run word arrived: set up the zero sequence
    logic emit;        // one inserted zero left toward the output register
  } ctr_cmd_t;

  // Status from the run counter.
  typedef struct packed {
    logic busy;        // zeros still to go out for the current run word
    logic last;        // the next zero is the final one of this run word
  } ctr_sts_t;

endpackage

### design/zrld_run_ctr.sv
// Run counter: block fill count (saturating incrementer) and remaining-zero count (down counter).
module zrld_run_ctr #(
  parameter int BLOCK_LEN = zrld_pkg::BLOCK_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  zrld_pkg::ctr_cmd_t                 cmd,
  input  logic signed [zrld_pkg::WORD_W-1:0] run_word,
  output zrld_pkg::ctr_sts_t                 sts
);

  localparam int CNT_W = $clog2(BLOCK_LEN + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(BLOCK_LEN);
  localparam logic signed [zrld_pkg::WORD_W-1:0] RUN_END = zrld_pkg::WORD_W'(BLOCK_LEN - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             end_r, end_nxt;
  logic [CNT_W-1:0] count_inc;

  // Saturating bump of the block fill count.
  assign count_inc = (count_r < FULL) ? count_r + CNT_W'(1) : count_r;

  always_comb begin
    count_nxt  = count_r;
    remain_nxt = remain_r;
    end_nxt    = end_r;
    if (cmd.load_coeff) begin
      count_nxt = count_inc;
    end else if (cmd.load_run) begin
      if (run_word <= 0) begin
        remain_nxt = '0;
        end_nxt    = 1'b0;
      end else if (run_word < RUN_END) begin
        remain_nxt = run_word[CNT_W-1:0];
        end_nxt    = 1'b0;
      end else begin
        // Fill the rest of the block; clear at once if already full.
        remain_nxt = FULL - count_r;
        end_nxt    = 1'b1;
        if (count_r == FULL) begin
          count_nxt = '0;
        end
      end
    end else if (cmd.emit) begin
      remain_nxt = remain_r - CNT_W'(1);
      if (end_r && (remain_r == CNT_W'(1))) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      remain_r <= '0;
      end_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      end_r    <= end_nxt;
    end
  end

  assign sts.busy = (remain_r != '0);
  assign sts.last = (remain_r == CNT_W'(1));

endmodule

### design/zero_run_length_decoder.sv
// Top level of the zero-run-length decoder.
// Words arrive alternately as a coefficient and a zero-run length, starting with a
// coefficient after reset. A coefficient leaves as one result with last_of_run set.
// A run word inserts 1 to BLOCK_LEN-2 zeros for a short run, or enough zeros to
// complete BLOCK_LEN values for a run of BLOCK_LEN-1 or more (which also ends the
// block). A run of zero or a negative run gives no result. The zeros come one per
// cycle, while the output is not stalled, from a single down counter in the run
// counter, and in_ready stays low until the last one has been loaded into the output
// register. A word is taken only while the output register is empty or draining in
// that same cycle, so a result that waits on out_ready also holds off the next word.
module zero_run_length_decoder #(
  parameter int BLOCK_LEN = zrld_pkg::BLOCK_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [zrld_pkg::WORD_W-1:0] in_word_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [zrld_pkg::WORD_W-1:0] out_coeff_out,
  output logic                               out_last_of_run
);

  logic                               expect_run_r, expect_run_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [zrld_pkg::WORD_W-1:0] out_coeff_r, out_coeff_nxt;
  logic                               out_last_r, out_last_nxt;
  logic                               out_free;
  logic                               in_fire;
  zrld_pkg::ctr_cmd_t                 cmd;
  zrld_pkg::ctr_sts_t                 sts;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  // Take a word only when no zeros are pending and the output slot is free.
  assign in_ready = !sts.busy && out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    expect_run_nxt = expect_run_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_coeff_nxt  = out_coeff_r;
    out_last_nxt   = out_last_r;
    cmd            = '0;
    if (in_fire) begin
      if (!expect_run_r) begin
        // Pass the coefficient straight to the output register.
        out_valid_nxt  = 1'b1;
        out_coeff_nxt  = in_word_in;
        out_last_nxt   = 1'b1;
        cmd.load_coeff = 1'b1;
        expect_run_nxt = 1'b1;
      end else begin
        // Hand the run length to the counter; zeros follow once it is loaded and the output slot is free.
        cmd.load_run   = 1'b1;
        expect_run_nxt = 1'b0;
      end
    end else if (sts.busy && out_free) begin
      // Advance the run: push one inserted zero.
      out_valid_nxt = 1'b1;
      out_coeff_nxt = '0;
      out_last_nxt  = sts.last;
      cmd.emit      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_run_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      expect_run_r <= expect_run_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Hold payload without reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    out_coeff_r <= out_coeff_nxt;
    out_last_r  <= out_last_nxt;
  end

  zrld_run_ctr #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_run_ctr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .run_word (in_word_in),
    .sts      (sts)
  );

  assign out_valid       = out_valid_r;
  assign out_coeff_out   = out_coeff_r;
  assign out_last_of_run = out_last_r;

endmodule
